// ===== sv/rdc_pkg.sv =====
// shared constants, types and helpers for the radix digit converter
package rdc_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
    localparam int unsigned SP_W        = ADDR_W + 1;

    localparam int unsigned STEPS_PER_CYCLE = 8;
    localparam int unsigned DIV_CYCLES      = VALUE_W / STEPS_PER_CYCLE;
    localparam int unsigned DIV_CNT_W       = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_A      = CHAR_W'(65);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

    typedef struct packed {
        logic                  done;
        logic [VALUE_W-1:0]    quotient;
        logic [DIGIT_W-1:0]    remainder;
    } t_div_res;

    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

// ===== sv/rdc_ram.sv =====
// generic single-port-write ram with registered read
module rdc_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rdc_div.sv =====
// iterative restoring divider, several quotient bits per cycle
module rdc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rdc_pkg::VALUE_W-1:0] i_dividend,
    input  logic [rdc_pkg::RADIX_W-1:0] i_divisor,
    output rdc_pkg::t_div_res           o_res
);

    logic                          r_run;
    logic                          r_done;
    logic [rdc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [rdc_pkg::VALUE_W-1:0]   r_q;
    logic [rdc_pkg::RADIX_W-1:0]   r_rem;
    logic [rdc_pkg::RADIX_W-1:0]   r_div;

    logic [rdc_pkg::VALUE_W-1:0]   n_q;
    logic [rdc_pkg::RADIX_W-1:0]   n_rem;

    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        for (int i = 0; i < int'(rdc_pkg::STEPS_PER_CYCLE); i++) begin
            n_rem = {n_rem[rdc_pkg::RADIX_W-2:0], n_q[rdc_pkg::VALUE_W-1]};
            n_q   = {n_q[rdc_pkg::VALUE_W-2:0], 1'b0};
            if (n_rem >= r_div) begin
                n_rem  = n_rem - r_div;
                n_q[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rdc_pkg::DIV_CNT_W'(rdc_pkg::DIV_CYCLES - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_q;
    assign o_res.remainder = r_rem[rdc_pkg::DIGIT_W-1:0];

endmodule

// ===== sv/radix_digit_converter_unit.sv =====
// top level: converts a 32-bit value into ascii digits of a programmable radix
//
// usage: drive i_value and pulse start while busy is low; the item is taken at
// that edge. busy stays high until the last character has been shown.
// the radix register is written through i_cfg_we / i_cfg_wdata while idle;
// values below 2 act as 2 and values above 16 act as 16. reset sets it to 10.
// results: one character per cycle on o_digit_char with o_digit_strobe high,
// most significant first; o_last_digit marks the least significant one.
// the receiver cannot stall, each character is shown for one cycle only.
// a value of zero gives no characters and busy stays low.
// each digit needs one division in the shared divider plus a handoff in which
// the remainder is pushed onto the digit stack and, if the quotient is not yet
// zero, the next division starts; then the digit stack is read out at one
// character per cycle through the registered stack ram.
// reset (synchronous, active low) returns the sequencer to idle with an empty
// stack; stack contents are not cleared.
module radix_digit_converter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rdc_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_cfg_we,
    input  logic [rdc_pkg::RADIX_W-1:0]   i_cfg_wdata,
    output logic                          o_digit_strobe,
    output logic [rdc_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                          o_last_digit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [rdc_pkg::SP_W-1:0]     r_sp, n_sp;
    logic [rdc_pkg::RADIX_W-1:0]  r_radix;
    logic [rdc_pkg::RADIX_W-1:0]  r_base, n_base;
    logic                         r_rd_pend, n_rd_pend;
    logic                         r_rd_last, n_rd_last;

    rdc_pkg::t_div_res            div_res;
    logic                         div_start;
    logic [rdc_pkg::VALUE_W-1:0]  div_dividend;
    logic [rdc_pkg::RADIX_W-1:0]  div_divisor;

    logic                         ram_we;
    logic [rdc_pkg::ADDR_W-1:0]   ram_waddr;
    logic [rdc_pkg::ADDR_W-1:0]   ram_raddr;
    logic [rdc_pkg::DIGIT_W-1:0]  ram_rdata;
    logic [rdc_pkg::SP_W-1:0]     sp_dec;

    assign busy   = (r_state != ST_IDLE) || r_rd_pend;
    assign sp_dec = r_sp - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_base       = r_base;
        n_rd_pend    = 1'b0;
        n_rd_last    = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_res.quotient;
        div_divisor  = r_base;
        ram_we       = 1'b0;
        ram_waddr    = r_sp[rdc_pkg::ADDR_W-1:0];
        ram_raddr    = sp_dec[rdc_pkg::ADDR_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                div_dividend = i_value;
                div_divisor  = rdc_pkg::effective_radix(r_radix);
                if (start && !busy && (i_value != '0)) begin
                    n_base    = rdc_pkg::effective_radix(r_radix);
                    n_sp      = '0;
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    ram_we = (r_sp < rdc_pkg::SP_W'(rdc_pkg::STACK_DEPTH));
                    if (ram_we) begin
                        n_sp = r_sp + 1'b1;
                    end
                    if (div_res.quotient == '0) begin
                        n_state = ST_POP;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_POP: begin
                n_sp      = sp_dec;
                n_rd_pend = 1'b1;
                n_rd_last = (sp_dec == '0);
                if (sp_dec == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= '0;
            r_radix   <= rdc_pkg::RADIX_RESET;
            r_base    <= rdc_pkg::RADIX_RESET;
            r_rd_pend <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_base    <= n_base;
            r_rd_pend <= n_rd_pend;
            r_rd_last <= n_rd_last;
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    rdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_res      (div_res)
    );

    rdc_ram #(
        .WIDTH (rdc_pkg::DIGIT_W),
        .DEPTH (rdc_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (div_res.remainder),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_digit_strobe = r_rd_pend;
    assign o_digit_char   = rdc_pkg::digit_to_ascii(ram_rdata);
    assign o_last_digit   = r_rd_last;

endmodule
